// ===== design/ascs_pkg.sv =====
// Shared types, constants and helpers for the Annex B start code splitter.
// Depends on nothing; the front, queue, back and top-level files import it.
package ascs_pkg;

   localparam int POS_BITS  = 32;
   localparam int OUT_BITS  = 32;
   localparam int WIDE_BITS = ((POS_BITS > OUT_BITS) ? POS_BITS : OUT_BITS) + 1;
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   typedef logic [POS_BITS-1:0]  pos_type;
   typedef logic [WIDE_BITS-1:0] wide_type;
   typedef logic [OUT_BITS-1:0]  out_type;

   localparam pos_type  POS_MAX    = {POS_BITS{1'b1}};
   localparam wide_type OUT_MAX_W  = {{(WIDE_BITS-OUT_BITS){1'b0}}, {OUT_BITS{1'b1}}};

   // Header bytes that qualify a start code.
   localparam logic [7:0] HDR_SLICE     = 8'h41;
   localparam logic [7:0] HDR_SPS       = 8'h67;
   localparam logic [7:0] HDR_SPS_ALT   = 8'h40;
   localparam logic [7:0] HDR_DELIMITER = 8'h02;

   // Start code lengths, and the scan-distance ceiling.
   localparam logic [2:0] SC_LONG_BYTES  = 3'd4;
   localparam logic [2:0] SC_SHORT_BYTES = 3'd3;
   localparam logic [2:0] SC_NONE        = 3'd0;
   localparam logic [2:0] SKIP_MAX       = 3'd4;

   // Up to two frame reports caused by one stream byte.
   typedef struct packed {
      logic    has_start;   // frame closed by a new start code
      out_type start_off;
      out_type start_len;
      logic    has_end;     // frame closed by end of stream
      out_type end_off;
      out_type end_len;
   } ascs_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } ascs_qstat_type;

   function automatic out_type sat_out(input wide_type v);
      return (v > OUT_MAX_W) ? {OUT_BITS{1'b1}} : v[OUT_BITS-1:0];
   endfunction

endpackage

// ===== design/ascs_front.sv =====
// Front end: accepts stream bytes, finds start codes and builds frame reports.
// Depends on ascs_pkg.
module ascs_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_end_of_stream,
   input  ascs_pkg::ascs_qstat_type qstat,
   output logic                   push,
   output ascs_pkg::ascs_entry_type push_entry
);
   import ascs_pkg::*;

   logic [7:0] win_ff [4];
   logic [7:0] win_in [4];
   logic [2:0] skip_ff, skip_in;
   pos_type    pos_ff, pos_in;
   pos_type    ofs_ff, ofs_in;
   logic       open_ff, open_in;

   logic       accept;
   logic       hdr;
   logic [2:0] back;
   logic       match;
   pos_type    q;
   pos_type    new_ofs;
   logic       new_open;
   wide_type   start_len;
   wide_type   end_len;

   assign req_stall = qstat.full;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      hdr = req_data_byte inside {HDR_SLICE, HDR_SPS, HDR_SPS_ALT, HDR_DELIMITER};
      if (skip_ff >= SC_LONG_BYTES && win_ff[0] == 8'h00 && win_ff[1] == 8'h00 &&
          win_ff[2] == 8'h00 && win_ff[3] == 8'h01 && hdr) begin
         back = SC_LONG_BYTES;
      end else if (skip_ff >= SC_SHORT_BYTES && win_ff[1] == 8'h00 &&
                   win_ff[2] == 8'h00 && win_ff[3] == 8'h01 && hdr) begin
         back = SC_SHORT_BYTES;
      end else begin
         back = SC_NONE;
      end
      match = (back != SC_NONE);

      q = (pos_ff >= POS_BITS'(back)) ? pos_ff - POS_BITS'(back) : '0;
      start_len = (q >= ofs_ff) ? WIDE_BITS'(q) - WIDE_BITS'(ofs_ff) : '0;

      new_ofs  = match ? q : ofs_ff;
      new_open = match | open_ff;
      end_len  = (pos_ff >= new_ofs)
                 ? WIDE_BITS'(pos_ff) - WIDE_BITS'(new_ofs) + WIDE_BITS'(1) : '0;

      push_entry.has_start = match & open_ff;
      push_entry.start_off = sat_out(WIDE_BITS'(ofs_ff));
      push_entry.start_len = sat_out(start_len);
      push_entry.has_end   = req_end_of_stream & new_open;
      push_entry.end_off   = sat_out(WIDE_BITS'(new_ofs));
      push_entry.end_len   = sat_out(end_len);
      push = accept & (push_entry.has_start | push_entry.has_end);

      win_in  = win_ff;
      skip_in = skip_ff;
      pos_in  = pos_ff;
      ofs_in  = ofs_ff;
      open_in = open_ff;
      if (accept) begin
         if (req_end_of_stream) begin
            // The stream ends here; the next byte starts a fresh stream.
            for (int i = 0; i < 4; i++) begin
               win_in[i] = 8'h00;
            end
            skip_in = '0;
            pos_in  = '0;
            ofs_in  = '0;
            open_in = 1'b0;
         end else begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = win_ff[3];
            win_in[3] = req_data_byte;
            skip_in   = match ? 3'd1 : ((skip_ff < SKIP_MAX) ? skip_ff + 3'd1 : skip_ff);
            pos_in    = (pos_ff < POS_MAX) ? pos_ff + POS_BITS'(1) : pos_ff;
            ofs_in    = new_ofs;
            open_in   = new_open;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            win_ff[i] <= 8'h00;
         end
         skip_ff <= '0;
         pos_ff  <= '0;
         ofs_ff  <= '0;
         open_ff <= 1'b0;
      end else begin
         win_ff  <= win_in;
         skip_ff <= skip_in;
         pos_ff  <= pos_in;
         ofs_ff  <= ofs_in;
         open_ff <= open_in;
      end
   end

endmodule

// ===== design/ascs_queue.sv =====
// Short queue of frame report entries between front and back end.
// Depends on ascs_pkg.
module ascs_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ascs_pkg::ascs_entry_type push_entry,
   input  logic                     pop,
   output ascs_pkg::ascs_qstat_type qstat,
   output ascs_pkg::ascs_entry_type head_entry
);
   import ascs_pkg::*;

   ascs_entry_type         mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign qstat.full      = (count_ff == QCNT_BITS'(QDEPTH));
   assign qstat.not_empty = (count_ff != '0);
   assign head_entry      = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push & ~qstat.full;
      do_pop    = pop & qstat.not_empty;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/ascs_back.sv =====
// Back end: serializes queued entries into one frame report per cycle while rsp_stall is low.
// Depends on ascs_pkg.
module ascs_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ascs_pkg::ascs_qstat_type qstat,
   input  ascs_pkg::ascs_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [31:0]              rsp_frame_offset,
   output logic [31:0]              rsp_frame_length,
   output logic                     rsp_closed_by_end,
   output logic                     rsp_run_last
);
   import ascs_pkg::*;

   logic    valid_ff, valid_in;
   logic    second_ff, second_in;   // start-code report of the head entry already sent
   out_type off_ff, off_in;
   out_type len_ff, len_in;
   logic    by_end_ff, by_end_in;
   logic    last_ff, last_in;
   logic    load;

   always_comb begin
      load      = ~valid_ff | ~rsp_stall;
      pop       = 1'b0;
      valid_in  = valid_ff;
      second_in = second_ff;
      off_in    = off_ff;
      len_in    = len_ff;
      by_end_in = by_end_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = qstat.not_empty;
         if (qstat.not_empty && head_entry.has_start && !second_ff) begin
            off_in    = head_entry.start_off;
            len_in    = head_entry.start_len;
            by_end_in = 1'b0;
            last_in   = ~head_entry.has_end;
            second_in = head_entry.has_end;
            pop       = ~head_entry.has_end;
         end else if (qstat.not_empty) begin
            off_in    = head_entry.end_off;
            len_in    = head_entry.end_len;
            by_end_in = 1'b1;
            last_in   = 1'b1;
            second_in = 1'b0;
            pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      off_ff    <= off_in;
      len_ff    <= len_in;
      by_end_ff <= by_end_in;
      last_ff   <= last_in;
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_frame_offset  = off_ff;
   assign rsp_frame_length  = len_ff;
   assign rsp_closed_by_end = by_end_ff;
   assign rsp_run_last      = last_ff;

endmodule

// ===== design/annexb_start_code_splitter_unit.sv =====
// Annex B start code splitter: one stream byte accepted per cycle while req_stall is low,
// one frame report delivered per cycle while rsp_stall is low. Each report is registered
// in the queue, then in the back end. A byte at end of stream can cause two reports;
// both share one queue entry. Input stalls only when the four-entry report queue is full.
// Synchronous active-high reset clears the scan window, counters, queue and output.
// Depends on ascs_pkg, ascs_front, ascs_queue and ascs_back.
module annexb_start_code_splitter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_frame_offset,
   output logic [31:0] rsp_frame_length,
   output logic        rsp_closed_by_end,
   output logic        rsp_run_last
);
   import ascs_pkg::*;

   // The front end owns the four-byte window and the position counters. Each
   // request that closes a frame produces one queue entry holding the frame
   // closed by a new start code and/or the frame closed by end of stream.
   ascs_qstat_type qstat;
   ascs_entry_type push_entry;
   ascs_entry_type head_entry;
   logic           push;
   logic           pop;

   ascs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .qstat             (qstat),
      .push              (push),
      .push_entry        (push_entry)
   );

   // The queue decouples the two sides, so a stalled consumer does not stop
   // the scan until four entries are waiting.
   ascs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .qstat      (qstat),
      .head_entry (head_entry)
   );

   // The back end sends the start-code report first, then the end-of-stream
   // report, marking the final one of each request with run_last.
   ascs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_offset  (rsp_frame_offset),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_closed_by_end (rsp_closed_by_end),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

// ===== design/ascs_checker.sv =====
// Port-level checks for the Annex B start code splitter, bound to the top level.
// Depends on annexb_start_code_splitter_unit.
module ascs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_frame_offset,
   input logic [31:0] rsp_frame_length,
   input logic        rsp_closed_by_end,
   input logic        rsp_run_last
);

   // A stalled report holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_offset) &&
         $stable(rsp_frame_length) && $stable(rsp_run_last))
      else $error("report changed while stalled");

   // An end-of-stream report always closes its request's run.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_closed_by_end || rsp_run_last)
      else $error("end-of-stream report without run_last");

   // A report that is not last is followed at once by the end-of-stream report.
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid && rsp_closed_by_end)
      else $error("second report of a pair missing");

   // No report right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("report valid after reset");

endmodule

bind annexb_start_code_splitter_unit ascs_checker u_ascs_checker (.*);
